// ----- design/acc_tilt_pkg.sv -----
package acc_tilt_pkg;

    // cordic vector: 16-bit sample, 24 fraction bits, headroom for gain and pre-rotation
    localparam int IN_W     = 16;
    localparam int IN_SCALE = 24;
    localparam int VW       = 43;

    // angle accumulator in degrees * 2^16
    localparam int ACC_FRAC = 16;
    localparam int AW       = 28;

    localparam int TBL_LEN = 24;
    localparam int TBL_IW  = 5;

    localparam logic signed [AW-1:0] DEG90  = 28'sd5898240;
    localparam logic signed [AW-1:0] DEG180 = 28'sd11796480;
    localparam logic signed [AW-1:0] DEG270 = 28'sd17694720;

    typedef struct packed {
        logic signed [VW-1:0] c;
        logic signed [VW-1:0] s;
        logic signed [AW-1:0] ang;
        logic                 fixed;
    } t_lane;

    // atan(2^-i) in degrees * 2^16, rounded to nearest
    function automatic logic signed [AW-1:0] f_atan(input logic [TBL_IW-1:0] idx);
        logic signed [AW-1:0] v;
        case (idx)
            5'd0:    v = 28'sd2949120;
            5'd1:    v = 28'sd1740967;
            5'd2:    v = 28'sd919879;
            5'd3:    v = 28'sd466945;
            5'd4:    v = 28'sd234379;
            5'd5:    v = 28'sd117304;
            5'd6:    v = 28'sd58666;
            5'd7:    v = 28'sd29335;
            5'd8:    v = 28'sd14668;
            5'd9:    v = 28'sd7334;
            5'd10:   v = 28'sd3667;
            5'd11:   v = 28'sd1833;
            5'd12:   v = 28'sd917;
            5'd13:   v = 28'sd458;
            5'd14:   v = 28'sd229;
            5'd15:   v = 28'sd115;
            5'd16:   v = 28'sd57;
            5'd17:   v = 28'sd29;
            5'd18:   v = 28'sd14;
            5'd19:   v = 28'sd7;
            5'd20:   v = 28'sd4;
            5'd21:   v = 28'sd2;
            5'd22:   v = 28'sd1;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/accel_tilt_angles.sv -----
// accel_tilt_angles: roll and pitch tilt angles from one accelerometer sample.
// input: i_accel_x/y/z (signed raw counts) are taken as one item at a rising
// edge where start is high and busy is low. busy is high only while reset is
// applied and on the cycle after, so a new item may enter on every cycle.
// output: o_roll_angle and o_pitch_angle (degrees * 2^ANGLE_FRAC_BITS,
// rounded to nearest) are shown for exactly one cycle with o_valid high.
// roll is atan2(y, z); pitch is atan2(z, x) + 180 wrapped by -270/+90.
// the result passes through one pre-rotation stage, one stage per cordic
// iteration, one pitch wrap stage and one rounding stage, all registered,
// before it is on the outputs.
// throughput: one item per cycle,
// set by the fully unrolled pair of vectoring cordic pipelines.
// iterations beyond 24 are not built; CORDIC_STEPS above 24 runs 24.
// reset clears all valid bits, so no result comes out of a flushed pipe.
// the receiver cannot stall: o_valid is not held and items are never lost.
module accel_tilt_angles
    import acc_tilt_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [IN_W-1:0] i_accel_x,
    input  logic signed [IN_W-1:0] i_accel_y,
    input  logic signed [IN_W-1:0] i_accel_z,
    output logic                   o_valid,
    output logic signed [15:0]     o_roll_angle,
    output logic signed [15:0]     o_pitch_angle
);

    localparam int NSTEP = (CORDIC_STEPS > TBL_LEN) ? TBL_LEN : CORDIC_STEPS;
    localparam int K     = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [AW-1:0] HALF = AW'(1 << (K - 1));
    localparam logic signed [AW-1:0] LIM  = AW'(180 << ANGLE_FRAC_BITS);

    // set up one atan2(s, c): exact axis cases bypass, left half plane turned by 180
    function automatic t_lane f_pre(input logic signed [IN_W-1:0] s_in,
                                    input logic signed [IN_W-1:0] c_in);
        t_lane                l;
        logic signed [VW-1:0] s_ext;
        logic signed [VW-1:0] c_ext;
        s_ext   = {{(VW-IN_W-IN_SCALE){s_in[IN_W-1]}}, s_in, {IN_SCALE{1'b0}}};
        c_ext   = {{(VW-IN_W-IN_SCALE){c_in[IN_W-1]}}, c_in, {IN_SCALE{1'b0}}};
        l.c     = c_ext;
        l.s     = s_ext;
        l.ang   = '0;
        l.fixed = 1'b0;
        if (s_in == '0) begin
            l.fixed = 1'b1;
            l.ang   = c_in[IN_W-1] ? DEG180 : '0;
        end else if (c_in == '0) begin
            l.fixed = 1'b1;
            l.ang   = s_in[IN_W-1] ? -DEG90 : DEG90;
        end else if (c_in[IN_W-1]) begin
            l.ang = s_in[IN_W-1] ? -DEG180 : DEG180;
            l.c   = -c_ext;
            l.s   = -s_ext;
        end
        return l;
    endfunction

    // one vectoring micro-rotation with a fixed shift
    function automatic t_lane f_rot(input t_lane a, input int unsigned sh,
                                    input logic signed [AW-1:0] da);
        t_lane l;
        l = a;
        if (!a.fixed) begin
            if (!a.s[VW-1]) begin
                l.c   = a.c + (a.s >>> sh);
                l.s   = a.s - (a.c >>> sh);
                l.ang = a.ang + da;
            end else begin
                l.c   = a.c - (a.s >>> sh);
                l.s   = a.s + (a.c >>> sh);
                l.ang = a.ang - da;
            end
        end
        return l;
    endfunction

    // degrees * 2^16 to output units, half up, clamped to +-180
    function automatic logic signed [AW-1:0] f_round(input logic signed [AW-1:0] w);
        logic signed [AW-1:0] r;
        r = (w + HALF) >>> K;
        if (r > LIM) begin
            r = LIM;
        end else if (r < -LIM) begin
            r = -LIM;
        end
        return r;
    endfunction

    logic  r_busy;
    logic  r_vld   [0:NSTEP];
    t_lane r_roll  [0:NSTEP];
    t_lane r_pitch [0:NSTEP];

    logic                 r_wvld;
    logic signed [AW-1:0] r_wroll;
    logic signed [AW-1:0] r_wpitch;
    logic signed [AW-1:0] n_a;
    logic signed [AW-1:0] n_wpitch;

    assign busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            for (int j = 0; j <= NSTEP; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            r_busy   <= 1'b0;
            r_vld[0] <= start & ~r_busy;
            for (int j = 0; j < NSTEP; j++) begin
                r_vld[j+1] <= r_vld[j];
            end
        end
        r_roll[0]  <= f_pre(i_accel_y, i_accel_z);
        r_pitch[0] <= f_pre(i_accel_z, i_accel_x);
        // one stage per cordic iteration
        for (int j = 0; j < NSTEP; j++) begin
            r_roll[j+1]  <= f_rot(r_roll[j], unsigned'(j), f_atan(TBL_IW'(j)));
            r_pitch[j+1] <= f_rot(r_pitch[j], unsigned'(j), f_atan(TBL_IW'(j)));
        end
    end

    // pitch wrap at full accumulator precision
    always_comb begin
        n_a = r_pitch[NSTEP].ang + DEG180;
        if (n_a > DEG90) begin
            n_wpitch = n_a - DEG270;
        end else begin
            n_wpitch = n_a + DEG90;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_wvld  <= r_vld[NSTEP];
            o_valid <= r_wvld;
        end
        r_wroll       <= r_roll[NSTEP].ang;
        r_wpitch      <= n_wpitch;
        o_roll_angle  <= 16'(f_round(r_wroll));
        o_pitch_angle <= 16'(f_round(r_wpitch));
    end

endmodule
